FILE: hw/rtl/gts_pkg.sv
// Package: types, constants and codes of the grid trilinear sampler.
package gts_pkg;

	localparam int GRID_SIDE_DEF = 32;
	localparam int COORD_W       = 24;
	localparam int SAMPLE_W      = 20;
	localparam int FRAC_W        = 10;
	localparam int DIV_W         = 20;
	localparam int IDX_W         = 10;
	localparam int WGT_W         = 11;
	localparam int ACC_W         = 56;

	localparam logic [1:0] REG_SPACING     = 2'd0;
	localparam logic [1:0] REG_GRID_WIDTH  = 2'd1;
	localparam logic [1:0] REG_GRID_HEIGHT = 2'd2;
	localparam logic [1:0] REG_GRID_DEPTH  = 2'd3;

	localparam logic       CMD_LOAD   = 1'b0;
	localparam logic       CMD_SAMPLE = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_BOUNDS  = 2'd1;
	localparam logic [1:0] STATUS_INVALID = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_CHECK,
		ST_READ,
		ST_DRAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                       command;
		logic [4:0]                 node_x;
		logic [4:0]                 node_y;
		logic [4:0]                 node_z;
		logic signed [COORD_W-1:0]  load_coord_x;
		logic signed [COORD_W-1:0]  load_coord_y;
		logic signed [COORD_W-1:0]  load_coord_z;
		logic                       load_invalid;
		logic signed [SAMPLE_W-1:0] sample_x;
		logic signed [SAMPLE_W-1:0] sample_y;
		logic signed [SAMPLE_W-1:0] sample_z;
	} in_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [COORD_W-1:0] interp_x;
		logic signed [COORD_W-1:0] interp_y;
		logic signed [COORD_W-1:0] interp_z;
	} out_t;

	typedef struct packed {
		logic                      invalid;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic signed [COORD_W-1:0] cz;
	} node_t;

	typedef struct packed {
		logic clear;
		logic issue;
	} mac_ctrl_t;

endpackage

FILE: hw/rtl/gts_div.sv
// Three-lane restoring divider by the node spacing, two quotient bits per cycle.
module gts_div (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [2:0][gts_pkg::DIV_W-1:0]        dividend,
	input  logic [4:0]                            divisor,
	output logic                                  done,
	output logic [2:0][gts_pkg::DIV_W-1:0]        quotient
);

	localparam int STEPS = gts_pkg::DIV_W / 2;

	logic [2:0][gts_pkg::DIV_W-1:0] dvd_q;
	logic [2:0][4:0]                rem_q;
	logic [4:0]                     div_q;
	logic [3:0]                     cnt_q;
	logic                           busy_q;
	logic [2:0][gts_pkg::DIV_W-1:0] dvd_n;
	logic [2:0][4:0]                rem_n;

	always_comb begin
		logic [5:0] r;
		for (int l = 0; l < 3; l++) begin
			dvd_n[l] = dvd_q[l];
			rem_n[l] = rem_q[l];
			for (int s = 0; s < 2; s++) begin
				r = {rem_n[l], dvd_n[l][gts_pkg::DIV_W-1]};
				dvd_n[l] = {dvd_n[l][gts_pkg::DIV_W-2:0], 1'b0};
				if (r >= {1'b0, div_q}) begin
					rem_n[l] = 5'(r - {1'b0, div_q});
					dvd_n[l][0] = 1'b1;
				end else begin
					rem_n[l] = r[4:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= dvd_n;
			rem_q <= rem_n;
		end
	end

	assign quotient = dvd_q;

endmodule

FILE: hw/rtl/gts_node_mem.sv
// Node memory: one write port, one read port with registered read data.
module gts_node_mem #(
	parameter int AW = 15
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  gts_pkg::node_t        wdata,
	input  logic [AW-1:0]         raddr,
	output gts_pkg::node_t        rdata
);

	gts_pkg::node_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/gts_mac.sv
// Weight product and multiply-accumulate pipeline over the eight neighbours.
module gts_mac (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  gts_pkg::mac_ctrl_t                      ctrl,
	input  logic [gts_pkg::WGT_W-1:0]               wx,
	input  logic [gts_pkg::WGT_W-1:0]               wy,
	input  logic [gts_pkg::WGT_W-1:0]               wz,
	input  gts_pkg::node_t                          rdata,
	output logic signed [2:0][gts_pkg::ACC_W-1:0]   acc,
	output logic                                    any_invalid
);

	localparam int WT_W = 31;
	localparam int P_W  = WT_W + 1 + gts_pkg::COORD_W;

	logic                           v_s1, v_s2, v_s3;
	logic [2*gts_pkg::WGT_W-1:0]    wxy_s1;
	logic [gts_pkg::WGT_W-1:0]      wz_s1;
	logic [WT_W-1:0]                wt_s2;
	gts_pkg::node_t                 node_s2;
	logic signed [2:0][P_W-1:0]     p_s3;
	logic                           inv_s3;
	logic [3*gts_pkg::WGT_W-1:0]    wt_full;

	assign wt_full = wxy_s1 * wz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		wxy_s1  <= wx * wy;
		wz_s1   <= wz;
		wt_s2   <= wt_full[WT_W-1:0];
		node_s2 <= rdata;
		p_s3[0] <= $signed({1'b0, wt_s2}) * node_s2.cx;
		p_s3[1] <= $signed({1'b0, wt_s2}) * node_s2.cy;
		p_s3[2] <= $signed({1'b0, wt_s2}) * node_s2.cz;
		inv_s3  <= node_s2.invalid;
	end

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			acc         <= '0;
			any_invalid <= 1'b0;
		end else if (v_s3) begin
			for (int c = 0; c < 3; c++) begin
				acc[c] <= acc[c] + gts_pkg::ACC_W'(p_s3[c]);
			end
			any_invalid <= any_invalid | inv_s3;
		end
	end

endmodule

FILE: hw/rtl/grid_trilinear_sampler_core.sv
// Top level: grid trilinear sampler with node memory, divider and MAC pipeline.
//
//  channel   direction  handshake               payload
//  in        in         in_valid / in_stall     gts_pkg::in_t
//  out       out        out_valid / out_stall   gts_pkg::out_t
//  apb       in/out     psel penable pwrite     paddr pwdata prdata pready
//
//  A sample transaction runs the divider (10 steps and the done flag), the bounds
//  check, 8 node reads on the single memory read port, the pipeline drain, the load
//  of the result register and the return to idle. A rejected sample skips the reads
//  and the drain. No clearing pass after reset.
//  in_stall is high while a sample is at work or its result waits for a full
//  output register.
module grid_trilinear_sampler_core #(
	parameter int GRID_SIDE = gts_pkg::GRID_SIDE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  gts_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output gts_pkg::out_t  out_data,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);

	localparam int IW = $clog2(GRID_SIDE);
	localparam int AW = 3 * IW;
	localparam int XW = gts_pkg::IDX_W;
	localparam logic [gts_pkg::WGT_W-1:0] WGT_ONE = gts_pkg::WGT_W'(1 << gts_pkg::FRAC_W);

	gts_pkg::state_t state_q, state_n;

	logic [4:0] spacing_q;
	logic [5:0] width_q, height_q, depth_q;

	logic                                in_acc;
	logic                                cfg_wr;
	logic [2:0]                          neg_q;
	logic [2:0][gts_pkg::DIV_W-1:0]      dvd;
	logic [2:0][gts_pkg::DIV_W-1:0]      quo;
	logic                                div_start, div_done;
	logic [4:0]                          divisor;
	logic [2:0][XW-1:0]                  size;
	logic [2:0][XW-1:0]                  lo, hi;
	logic [2:0][IW-1:0]                  lo_q, hi_q;
	logic [2:0][gts_pkg::FRAC_W-1:0]     fr_q;
	logic                                reject;
	logic                                rej_q;
	logic [2:0]                          k_q;
	logic [1:0]                          dcnt_q;
	logic                                we;
	logic [AW-1:0]                       waddr, raddr;
	gts_pkg::node_t                      wnode, rnode;
	gts_pkg::mac_ctrl_t                  mctl;
	logic [gts_pkg::WGT_W-1:0]           wx, wy, wz;
	logic signed [2:0][gts_pkg::ACC_W-1:0] acc;
	logic                                any_inv;
	logic                                out_load;
	gts_pkg::out_t                       res;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= 5'd1;
			width_q   <= 6'd32;
			height_q  <= 6'd32;
			depth_q   <= 6'd32;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				gts_pkg::REG_SPACING:     spacing_q <= pwdata[4:0];
				gts_pkg::REG_GRID_WIDTH:  width_q   <= pwdata[5:0];
				gts_pkg::REG_GRID_HEIGHT: height_q  <= pwdata[5:0];
				gts_pkg::REG_GRID_DEPTH:  depth_q   <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			gts_pkg::REG_SPACING:     prdata = {27'd0, spacing_q};
			gts_pkg::REG_GRID_WIDTH:  prdata = {26'd0, width_q};
			gts_pkg::REG_GRID_HEIGHT: prdata = {26'd0, height_q};
			gts_pkg::REG_GRID_DEPTH:  prdata = {26'd0, depth_q};
			default:                  prdata = '0;
		endcase
	end

	// input side
	assign in_stall = (state_q != gts_pkg::ST_IDLE);
	assign in_acc   = in_valid & ~in_stall;

	assign we = in_acc && (in_data.command == gts_pkg::CMD_LOAD)
		&& ({5'd0, in_data.node_x} < XW'(GRID_SIDE))
		&& ({5'd0, in_data.node_y} < XW'(GRID_SIDE))
		&& ({5'd0, in_data.node_z} < XW'(GRID_SIDE));
	assign waddr = {IW'(in_data.node_x), IW'(in_data.node_y), IW'(in_data.node_z)};
	assign wnode = '{invalid: in_data.load_invalid, cx: in_data.load_coord_x,
		cy: in_data.load_coord_y, cz: in_data.load_coord_z};

	assign div_start = in_acc && (in_data.command == gts_pkg::CMD_SAMPLE);
	assign divisor   = (spacing_q == 5'd0) ? 5'd1 : spacing_q;
	assign dvd[0] = {1'b0, in_data.sample_x[gts_pkg::SAMPLE_W-2:0]};
	assign dvd[1] = {1'b0, in_data.sample_y[gts_pkg::SAMPLE_W-2:0]};
	assign dvd[2] = {1'b0, in_data.sample_z[gts_pkg::SAMPLE_W-2:0]};

	always_ff @(posedge clk) begin
		if (div_start) begin
			neg_q <= {in_data.sample_z[gts_pkg::SAMPLE_W-1],
				in_data.sample_y[gts_pkg::SAMPLE_W-1],
				in_data.sample_x[gts_pkg::SAMPLE_W-1]};
		end
	end

	gts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quo)
	);

	// bounds check and neighbour indices
	always_comb begin
		logic [2:0][XW-1:0] raw;
		raw[0] = {4'd0, width_q};
		raw[1] = {4'd0, height_q};
		raw[2] = {4'd0, depth_q};
		reject = |neg_q;
		for (int d = 0; d < 3; d++) begin
			size[d] = (raw[d] > XW'(GRID_SIDE)) ? XW'(GRID_SIDE) : raw[d];
			lo[d]   = XW'(quo[d][gts_pkg::DIV_W-1:gts_pkg::FRAC_W]);
			hi[d]   = (XW'(lo[d] + XW'(1)) < size[d]) ? XW'(lo[d] + XW'(1))
				: XW'(size[d] - XW'(1));
			if (lo[d] >= size[d]) begin
				reject = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gts_pkg::ST_CHECK) begin
			rej_q <= reject;
			for (int d = 0; d < 3; d++) begin
				lo_q[d] <= IW'(lo[d]);
				hi_q[d] <= IW'(hi[d]);
				fr_q[d] <= quo[d][gts_pkg::FRAC_W-1:0];
			end
		end
	end

	// neighbour reads
	assign raddr = {k_q[2] ? hi_q[0] : lo_q[0], k_q[1] ? hi_q[1] : lo_q[1],
		k_q[0] ? hi_q[2] : lo_q[2]};
	assign wx = k_q[2] ? {1'b0, fr_q[0]} : WGT_ONE - {1'b0, fr_q[0]};
	assign wy = k_q[1] ? {1'b0, fr_q[1]} : WGT_ONE - {1'b0, fr_q[1]};
	assign wz = k_q[0] ? {1'b0, fr_q[2]} : WGT_ONE - {1'b0, fr_q[2]};

	gts_node_mem #(.AW(AW)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wnode),
		.raddr (raddr),
		.rdata (rnode)
	);

	assign mctl.clear = (state_q == gts_pkg::ST_CHECK);
	assign mctl.issue = (state_q == gts_pkg::ST_READ);

	gts_mac u_mac (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (mctl),
		.wx          (wx),
		.wy          (wy),
		.wz          (wz),
		.rdata       (rnode),
		.acc         (acc),
		.any_invalid (any_inv)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gts_pkg::ST_IDLE;
			k_q     <= '0;
			dcnt_q  <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == gts_pkg::ST_READ) begin
				k_q <= k_q + 3'd1;
			end else begin
				k_q <= '0;
			end
			if (state_q == gts_pkg::ST_DRAIN) begin
				dcnt_q <= dcnt_q + 2'd1;
			end else begin
				dcnt_q <= '0;
			end
		end
	end

	assign out_load = (state_q == gts_pkg::ST_DONE) && (!out_valid || !out_stall);

	always_comb begin
		state_n = state_q;
		case (state_q)
			gts_pkg::ST_IDLE:  if (div_start) state_n = gts_pkg::ST_DIV;
			gts_pkg::ST_DIV:   if (div_done) state_n = gts_pkg::ST_CHECK;
			gts_pkg::ST_CHECK: state_n = reject ? gts_pkg::ST_DONE : gts_pkg::ST_READ;
			gts_pkg::ST_READ:  if (k_q == 3'd7) state_n = gts_pkg::ST_DRAIN;
			gts_pkg::ST_DRAIN: if (dcnt_q == 2'd2) state_n = gts_pkg::ST_DONE;
			gts_pkg::ST_DONE:  if (out_load) state_n = gts_pkg::ST_IDLE;
			default:           state_n = gts_pkg::ST_IDLE;
		endcase
	end

	// result
	always_comb begin
		res = '0;
		if (rej_q) begin
			res.status = gts_pkg::STATUS_BOUNDS;
		end else if (any_inv) begin
			res.status = gts_pkg::STATUS_INVALID;
		end else begin
			res.status   = gts_pkg::STATUS_OK;
			res.interp_x = acc[0][53:30];
			res.interp_y = acc[1][53:30];
			res.interp_z = acc[2][53:30];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data <= res;
		end
	end

	// checks
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status != 2'd3)
		else $error("status code out of range");

	a_zero_unless_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != gts_pkg::STATUS_OK |->
		out_data.interp_x == '0 && out_data.interp_y == '0 && out_data.interp_z == '0)
		else $error("non-zero result with error status");

	a_sample_starts: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |=> state_q == gts_pkg::ST_DIV)
		else $error("sample transaction did not start the divider");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == gts_pkg::ST_IDLE)
		else $error("node write while a sample is at work");

endmodule
